[rtl/core/mtg_pkg.sv]
// shared types and constants for the mesh tangent generator
package mtg_pkg;

  localparam int IDX_W            = 10;
  localparam int DATA_W           = 32;
  localparam int SUM_W            = 48;
  localparam int MAX_VERTICES_DEF = 1024;

  // transaction operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_T_RD0,
    ST_T_RD1,
    ST_T_RD2,
    ST_T_LAT2,
    ST_T_MUL,
    ST_T_DVLD,
    ST_T_DIV,
    ST_T_ACC_RD,
    ST_T_ACC_WR,
    ST_R_RD,
    ST_R_LAT,
    ST_R_SHR,
    ST_R_DOT,
    ST_R_UMUL,
    ST_R_ZCHK,
    ST_R_NSHR,
    ST_R_NSHL,
    ST_R_SQ,
    ST_R_SQRT,
    ST_R_DVLD,
    ST_R_DIV,
    ST_OUT
  } state_t;

endpackage

[rtl/core/mesh_tangent_generator.sv]
// per-vertex tangent generator: vertex stores, shared multiplier, divider and root sequencer
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   input    | start, busy            | in_op, in_vertex_index, corners, position, uv, normal
//   result   | out_valid (strobe)     | out_tangent_x/y/z, out_zero_length
//
// a vertex load completes in the accepting cycle; triangles and readouts run the 79-step
// restoring divider once per component, readouts also the 32-step square root, all on one
// shared multiplier and one divider
// after reset the tangent sum store is cleared one row a cycle, busy high
// a result is shown for one cycle only; the receiver cannot stall it
module mesh_tangent_generator #(
  parameter int MAX_VERTICES = mtg_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic [mtg_pkg::IDX_W-1:0]           in_vertex_index,
  input  logic [mtg_pkg::IDX_W-1:0]           in_second_corner,
  input  logic [mtg_pkg::IDX_W-1:0]           in_third_corner,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_position_x,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_position_y,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_position_z,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_tex_u,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_tex_v,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_normal_x,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_normal_y,
  input  logic signed [mtg_pkg::DATA_W-1:0]   in_normal_z,
  output logic                                out_valid,
  output logic signed [mtg_pkg::DATA_W-1:0]   out_tangent_x,
  output logic signed [mtg_pkg::DATA_W-1:0]   out_tangent_y,
  output logic signed [mtg_pkg::DATA_W-1:0]   out_tangent_z,
  output logic                                out_zero_length
);
  import mtg_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic signed [SUM_W-1:0] LIM30 = 48'sh0000_4000_0000;
  localparam logic signed [SUM_W-1:0] LIM29 = 48'sh0000_2000_0000;

  // helpers
  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [IDX_W+AW-1:0] e;
    e = {{AW{1'b0}}, i};
    return e[AW-1:0];
  endfunction

  function automatic logic in_rng(input logic [IDX_W-1:0] i);
    return {{(32-IDX_W){1'b0}}, i} < 32'(MAX_VERTICES);
  endfunction

  function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a, b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return d[31:0];
  endfunction

  function automatic logic signed [47:0] sat_add48(input logic [47:0] a,
                                                   input logic signed [31:0] b);
    logic [48:0] s;
    s = {a[47], a} + {{17{b[31]}}, b};
    if (s[48] != s[47]) return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    return s[47:0];
  endfunction

  function automatic logic signed [47:0] shr1(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + {47'b0, v[47]};
    return t >>> 1;
  endfunction

  function automatic logic signed [63:0] shrtz16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + (v[63] ? 64'sh0000_FFFF : 64'sh0);
    return t >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic ovr(input logic signed [47:0] v, input logic signed [47:0] lim);
    return (v >= lim) || (v <= -lim);
  endfunction

  function automatic logic signed [31:0] div_fin(input logic neg, input logic big,
                                                 input logic [32:0] q);
    logic [32:0] nq;
    nq = -q;
    if (neg) begin
      if (big || q > 33'h0_8000_0000) return 32'sh8000_0000;
      return nq[31:0];
    end
    if (big || q > 33'h0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  // storage
  logic [3*DATA_W-1:0] pos_mem [MAX_VERTICES];
  logic [2*DATA_W-1:0] tex_mem [MAX_VERTICES];
  logic [3*DATA_W-1:0] nrm_mem [MAX_VERTICES];
  logic [3*SUM_W-1:0]  sum_mem [MAX_VERTICES];
  logic [3*DATA_W-1:0] pos_rd_r, nrm_rd_r;
  logic [2*DATA_W-1:0] tex_rd_r;
  logic [3*SUM_W-1:0]  sum_rd_r;

  // control
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r;
  logic [3:0]      stp_r;
  logic [1:0]      cmp_r;
  logic [6:0]      dcnt_r;
  logic [AW-1:0]   idx_r [3];
  logic            acc_w;

  // datapath registers
  logic signed [31:0] p0_r [3];
  logic signed [31:0] uv0_r [2];
  logic signed [31:0] e1_r [3];
  logic signed [31:0] e2_r [3];
  logic signed [31:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [63:0] mul_r, tmp_r, acc_r;
  logic signed [64:0] det_r;
  logic signed [64:0] num_r [3];
  logic [78:0]        dvd_r;
  logic [63:0]        dsr_r, rem_r;
  logic [32:0]        q_r;
  logic               big_r, neg_r;
  logic signed [31:0] res_r [3];
  logic               zl_r;
  logic signed [47:0] tv_r [3];
  logic signed [31:0] n_r [3];
  logic signed [31:0] d_r;
  logic [63:0]        sq_x_r, sq_r_r, sq_b_r;

  // combinational controls
  logic [AW-1:0]        rd_addr;
  logic                 vtx_we, sum_we;
  logic [AW-1:0]        vtx_wa, sum_wa;
  logic [3*SUM_W-1:0]   sum_wd;
  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   mul_full;

  // divider step
  logic [64:0] rem_sh, rem_df;
  logic        dv_ge;
  logic [63:0] rem_nx;
  logic [32:0] q_sh, q_fin;
  logic        big_fin;
  logic signed [64:0] ld_num;
  logic [64:0]        ld_nmag, ld_dmag;
  logic signed [47:0] ld_u;
  logic [47:0]        ld_umag;
  logic [63:0]        sq_rb;
  logic               any30, any29, all0;

  assign acc_w    = start && (state_r == ST_IDLE);
  assign mul_full = mul_a * mul_b;

  assign rem_sh  = {rem_r, dvd_r[78]};
  assign dv_ge   = rem_sh >= {1'b0, dsr_r};
  assign rem_df  = rem_sh - {1'b0, dsr_r};
  assign rem_nx  = dv_ge ? rem_df[63:0] : rem_sh[63:0];
  assign q_sh    = {q_r[31:0], dv_ge};
  assign q_fin   = big_r ? q_r : q_sh;
  assign big_fin = big_r | q_sh[32];

  assign ld_num  = num_r[cmp_r];
  assign ld_nmag = ld_num[64] ? -ld_num : ld_num;
  assign ld_dmag = det_r[64] ? -det_r : det_r;
  assign ld_u    = tv_r[cmp_r];
  assign ld_umag = ld_u[47] ? -ld_u : ld_u;
  assign sq_rb   = sq_r_r + sq_b_r;

  assign any30 = ovr(tv_r[0], LIM30) || ovr(tv_r[1], LIM30) || ovr(tv_r[2], LIM30);
  assign any29 = ovr(tv_r[0], LIM29) || ovr(tv_r[1], LIM29) || ovr(tv_r[2], LIM29);
  assign all0  = (tv_r[0] == '0) && (tv_r[1] == '0) && (tv_r[2] == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(MAX_VERTICES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc_w) begin
          if (in_op == OP_TRI) begin
            if (in_rng(in_vertex_index) && in_rng(in_second_corner) &&
                in_rng(in_third_corner)) state_nxt = ST_T_RD0;
          end else if (in_op == OP_READ) begin
            state_nxt = in_rng(in_vertex_index) ? ST_R_RD : ST_OUT;
          end
        end
      end
      ST_T_RD0:    state_nxt = ST_T_RD1;
      ST_T_RD1:    state_nxt = ST_T_RD2;
      ST_T_RD2:    state_nxt = ST_T_LAT2;
      ST_T_LAT2:   state_nxt = ST_T_MUL;
      ST_T_MUL:    if (stp_r == 4'd8) state_nxt = (det_r == '0) ? ST_IDLE : ST_T_DVLD;
      ST_T_DVLD:   state_nxt = ST_T_DIV;
      ST_T_DIV:    if (dcnt_r == '0) state_nxt = (cmp_r == 2'd2) ? ST_T_ACC_RD : ST_T_DVLD;
      ST_T_ACC_RD: state_nxt = ST_T_ACC_WR;
      ST_T_ACC_WR: state_nxt = (cmp_r == 2'd2) ? ST_IDLE : ST_T_ACC_RD;
      ST_R_RD:     state_nxt = ST_R_LAT;
      ST_R_LAT:    state_nxt = ST_R_SHR;
      ST_R_SHR:    if (!any30) state_nxt = ST_R_DOT;
      ST_R_DOT:    if (stp_r == 4'd3) state_nxt = ST_R_UMUL;
      ST_R_UMUL:   if (stp_r == 4'd3) state_nxt = ST_R_ZCHK;
      ST_R_ZCHK:   state_nxt = all0 ? ST_OUT : ST_R_NSHR;
      ST_R_NSHR:   if (!any30) state_nxt = ST_R_NSHL;
      ST_R_NSHL:   if (any29) state_nxt = ST_R_SQ;
      ST_R_SQ:     if (stp_r == 4'd3) state_nxt = ST_R_SQRT;
      ST_R_SQRT:   if (sq_b_r[0]) state_nxt = ST_R_DVLD;
      ST_R_DVLD:   state_nxt = ST_R_DIV;
      ST_R_DIV:    if (dcnt_r == '0) state_nxt = (cmp_r == 2'd2) ? ST_OUT : ST_R_DVLD;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: memory ports, multiplier operands, handshake
  always_comb begin
    rd_addr   = idx_r[0];
    vtx_we    = 1'b0;
    vtx_wa    = to_addr(in_vertex_index);
    sum_we    = 1'b0;
    sum_wa    = to_addr(in_vertex_index);
    sum_wd    = '0;
    mul_a     = '0;
    mul_b     = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_CLEAR: begin
        sum_we = 1'b1;
        sum_wa = clr_r;
      end
      ST_IDLE: begin
        if (acc_w && (in_op == OP_LOAD) && in_rng(in_vertex_index)) begin
          vtx_we = 1'b1;
          sum_we = 1'b1;
        end
      end
      ST_T_RD1: rd_addr = idx_r[1];
      ST_T_RD2: rd_addr = idx_r[2];
      ST_T_MUL: begin
        unique case (stp_r)
          4'd0:    begin mul_a = du1_r;   mul_b = dv2_r; end
          4'd1:    begin mul_a = du2_r;   mul_b = dv1_r; end
          4'd2:    begin mul_a = e1_r[0]; mul_b = dv2_r; end
          4'd3:    begin mul_a = e2_r[0]; mul_b = dv1_r; end
          4'd4:    begin mul_a = e1_r[1]; mul_b = dv2_r; end
          4'd5:    begin mul_a = e2_r[1]; mul_b = dv1_r; end
          4'd6:    begin mul_a = e1_r[2]; mul_b = dv2_r; end
          4'd7:    begin mul_a = e2_r[2]; mul_b = dv1_r; end
          default: begin mul_a = '0;      mul_b = '0;    end
        endcase
      end
      ST_T_ACC_RD: rd_addr = idx_r[cmp_r];
      ST_T_ACC_WR: begin
        sum_we = 1'b1;
        sum_wa = idx_r[cmp_r];
        for (int c = 0; c < 3; c++) begin
          sum_wd[c*SUM_W +: SUM_W] = sat_add48(sum_rd_r[c*SUM_W +: SUM_W], res_r[c]);
        end
      end
      ST_R_DOT: begin
        if (stp_r < 4'd3) begin
          mul_a = n_r[stp_r[1:0]];
          mul_b = tv_r[stp_r[1:0]][31:0];
        end
      end
      ST_R_UMUL: begin
        if (stp_r < 4'd3) begin
          mul_a = n_r[stp_r[1:0]];
          mul_b = d_r;
        end
      end
      ST_R_SQ: begin
        if (stp_r < 4'd3) begin
          mul_a = tv_r[stp_r[1:0]][31:0];
          mul_b = tv_r[stp_r[1:0]][31:0];
        end
      end
      default: ;
    endcase
  end

  // vertex attribute stores
  always_ff @(posedge clk) begin
    if (vtx_we) begin
      pos_mem[vtx_wa] <= {in_position_z, in_position_y, in_position_x};
    end
    pos_rd_r <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vtx_we) begin
      tex_mem[vtx_wa] <= {in_tex_v, in_tex_u};
    end
    tex_rd_r <= tex_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vtx_we) begin
      nrm_mem[vtx_wa] <= {in_normal_z, in_normal_y, in_normal_x};
    end
    nrm_rd_r <= nrm_mem[rd_addr];
  end

  // tangent sum store
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd_r <= sum_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      stp_r   <= '0;
      cmp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if ((state_r == ST_T_MUL) || (state_r == ST_R_DOT) ||
          (state_r == ST_R_UMUL) || (state_r == ST_R_SQ)) begin
        stp_r <= stp_r + 1'b1;
      end else begin
        stp_r <= '0;
      end
      if (acc_w) begin
        cmp_r <= '0;
      end else if (((state_r == ST_T_DIV) || (state_r == ST_R_DIV)) && (dcnt_r == '0)) begin
        cmp_r <= (cmp_r == 2'd2) ? 2'd0 : cmp_r + 1'b1;
      end else if (state_r == ST_T_ACC_WR) begin
        cmp_r <= cmp_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_r <= mul_full;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_w) begin
          idx_r[0] <= to_addr(in_vertex_index);
          idx_r[1] <= to_addr(in_second_corner);
          idx_r[2] <= to_addr(in_third_corner);
          for (int c = 0; c < 3; c++) res_r[c] <= '0;
          zl_r <= 1'b1;
        end
      end
      // corner fetch and differences
      ST_T_RD1: begin
        for (int c = 0; c < 3; c++) p0_r[c] <= pos_rd_r[c*DATA_W +: DATA_W];
        uv0_r[0] <= tex_rd_r[0 +: DATA_W];
        uv0_r[1] <= tex_rd_r[DATA_W +: DATA_W];
      end
      ST_T_RD2: begin
        for (int c = 0; c < 3; c++) e1_r[c] <= sat_sub32(pos_rd_r[c*DATA_W +: DATA_W], p0_r[c]);
        du1_r <= sat_sub32(tex_rd_r[0 +: DATA_W], uv0_r[0]);
        dv1_r <= sat_sub32(tex_rd_r[DATA_W +: DATA_W], uv0_r[1]);
      end
      ST_T_LAT2: begin
        for (int c = 0; c < 3; c++) e2_r[c] <= sat_sub32(pos_rd_r[c*DATA_W +: DATA_W], p0_r[c]);
        du2_r <= sat_sub32(tex_rd_r[0 +: DATA_W], uv0_r[0]);
        dv2_r <= sat_sub32(tex_rd_r[DATA_W +: DATA_W], uv0_r[1]);
      end
      // determinant and numerators, one product a cycle
      ST_T_MUL: begin
        unique case (stp_r)
          4'd1, 4'd3, 4'd5, 4'd7: tmp_r <= mul_r;
          4'd2:    det_r    <= {tmp_r[63], tmp_r} - {mul_r[63], mul_r};
          4'd4:    num_r[0] <= {tmp_r[63], tmp_r} - {mul_r[63], mul_r};
          4'd6:    num_r[1] <= {tmp_r[63], tmp_r} - {mul_r[63], mul_r};
          4'd8:    num_r[2] <= {tmp_r[63], tmp_r} - {mul_r[63], mul_r};
          default: ;
        endcase
      end
      // divider load for a tangent component
      ST_T_DVLD: begin
        dvd_r  <= {ld_nmag[62:0], 16'b0};
        dsr_r  <= ld_dmag[63:0];
        neg_r  <= ld_num[64] ^ det_r[64];
        rem_r  <= '0;
        q_r    <= '0;
        big_r  <= 1'b0;
        dcnt_r <= 7'd78;
      end
      // divider load for a normalized output component
      ST_R_DVLD: begin
        dvd_r  <= {15'b0, ld_umag, 16'b0};
        dsr_r  <= sq_r_r;
        neg_r  <= ld_u[47];
        rem_r  <= '0;
        q_r    <= '0;
        big_r  <= 1'b0;
        dcnt_r <= 7'd78;
      end
      // restoring division, one quotient bit a cycle
      ST_T_DIV, ST_R_DIV: begin
        dvd_r  <= {dvd_r[77:0], 1'b0};
        rem_r  <= rem_nx;
        dcnt_r <= dcnt_r - 1'b1;
        if (!big_r) begin
          q_r   <= q_sh;
          big_r <= q_sh[32];
        end
        if (dcnt_r == '0) res_r[cmp_r] <= div_fin(neg_r, big_fin, q_fin);
      end
      ST_R_LAT: begin
        for (int c = 0; c < 3; c++) begin
          tv_r[c] <= sum_rd_r[c*SUM_W +: SUM_W];
          n_r[c]  <= nrm_rd_r[c*DATA_W +: DATA_W];
        end
      end
      // prescale the sum below 2^30
      ST_R_SHR, ST_R_NSHR: begin
        if (any30) for (int c = 0; c < 3; c++) tv_r[c] <= shr1(tv_r[c]);
      end
      // dot product with the normal
      ST_R_DOT: begin
        unique case (stp_r)
          4'd1:    acc_r <= mul_r;
          4'd2:    acc_r <= acc_r + mul_r;
          4'd3:    d_r   <= sat32(shrtz16(acc_r + mul_r));
          default: ;
        endcase
      end
      // remove the normal part
      ST_R_UMUL: begin
        if (stp_r != 4'd0) begin
          tv_r[stp_r[1:0] - 2'd1] <= tv_r[stp_r[1:0] - 2'd1] - shrtz16(mul_r)[47:0];
        end
      end
      ST_R_ZCHK: if (!all0) zl_r <= 1'b0;
      // bring the largest component up to 2^29
      ST_R_NSHL: begin
        if (!any29) for (int c = 0; c < 3; c++) tv_r[c] <= tv_r[c] <<< 1;
      end
      // sum of squares
      ST_R_SQ: begin
        unique case (stp_r)
          4'd1: acc_r <= mul_r;
          4'd2: acc_r <= acc_r + mul_r;
          4'd3: begin
            sq_x_r <= acc_r + mul_r;
            sq_r_r <= '0;
            sq_b_r <= 64'h4000_0000_0000_0000;
          end
          default: ;
        endcase
      end
      // integer square root, one result bit a cycle
      ST_R_SQRT: begin
        if (sq_x_r >= sq_rb) begin
          sq_x_r <= sq_x_r - sq_rb;
          sq_r_r <= (sq_r_r >> 1) + sq_b_r;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
      end
      default: ;
    endcase
  end

  assign out_tangent_x   = res_r[0];
  assign out_tangent_y   = res_r[1];
  assign out_tangent_z   = res_r[2];
  assign out_zero_length = zl_r;

  // checks
  a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_w && (in_op == OP_READ)) |=> busy)
    else $error("read transaction did not hold the block busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_R_SQRT) |-> $onehot(sq_b_r))
    else $error("square root bit lost");

  a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T_DIV) |-> (dsr_r != '0))
    else $error("triangle division by zero determinant");

endmodule

[sim/mesh_tangent_generator_tb.sv]
// self-checking testbench for the mesh tangent generator
`timescale 1ns / 1ps

module mesh_tangent_generator_tb;
  import mtg_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NVERT = MAX_VERTICES_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] MAX_W = 32'h7fff_ffff;
  localparam logic [31:0] MIN_W = 32'h8000_0000;
  localparam wide_t S32_MAX = 128'sd2147483647;
  localparam wide_t S32_MIN = -128'sd2147483648;
  localparam wide_t S48_MAX = 128'sd140737488355327;
  localparam wide_t S48_MIN = -128'sd140737488355328;
  localparam wide_t TWO29 = 128'sd536870912;
  localparam wide_t TWO30 = 128'sd1073741824;
  localparam wide_t TWO31 = 128'sd2147483648;

  typedef struct {
    logic [1:0]  op;
    logic [9:0]  idx, c2, c3;
    logic [31:0] px, py, pz, tu, tv, nx, ny, nz;
    bit          typed_zero;
  } vtx_cmd_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               zl;
  } tangent_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_op;
  logic [IDX_W-1:0] in_vertex_index, in_second_corner, in_third_corner;
  logic signed [DATA_W-1:0] in_position_x, in_position_y, in_position_z;
  logic signed [DATA_W-1:0] in_tex_u, in_tex_v;
  logic signed [DATA_W-1:0] in_normal_x, in_normal_y, in_normal_z;
  logic out_valid;
  logic signed [DATA_W-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic out_zero_length;

  // vertex store copy kept by the predictor
  wide_t pos_mem [NVERT][3];
  wide_t uv_mem [NVERT][2];
  wide_t nrm_mem [NVERT][3];
  wide_t sum_mem [NVERT][3];

  tangent_t pending_tangents[$];
  vtx_cmd_t plan[$];
  bit loaded[NVERT];
  int loaded_list[$];
  bit failed = 0;
  int idle_cycles = 0;

  mesh_tangent_generator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex_index(in_vertex_index),
    .in_second_corner(in_second_corner), .in_third_corner(in_third_corner),
    .in_position_x(in_position_x), .in_position_y(in_position_y),
    .in_position_z(in_position_z), .in_tex_u(in_tex_u), .in_tex_v(in_tex_v),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .out_valid(out_valid), .out_tangent_x(out_tangent_x),
    .out_tangent_y(out_tangent_y), .out_tangent_z(out_tangent_z),
    .out_zero_length(out_zero_length)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic wide_t clamp(wide_t v, wide_t lo, wide_t hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic wide_t mag(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // divide by a power of two, rounding toward zero
  function automatic wide_t shr_tz(wide_t v, int s);
    wide_t m;
    m = mag(v) >>> s;
    return v < 0 ? -m : m;
  endfunction

  // (num * 2^16) / den toward zero, saturated to 32 bits
  function automatic wide_t div_q16(wide_t num, wide_t den);
    wide_t q;
    q = (mag(num) <<< 16) / mag(den);
    if ((num < 0) != (den < 0)) return q > TWO31 ? S32_MIN : -q;
    return q > S32_MAX ? S32_MAX : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // triangle tangent added into the sums of its three corners
  function automatic void accumulate_triangle(int a, int b, int c);
    wide_t e1[3], e2[3], t[3], du1, du2, dv1, dv2, det;
    int corner[3];
    corner = '{a, b, c};
    for (int k = 0; k < 3; k++) begin
      e1[k] = clamp(pos_mem[b][k] - pos_mem[a][k], S32_MIN, S32_MAX);
      e2[k] = clamp(pos_mem[c][k] - pos_mem[a][k], S32_MIN, S32_MAX);
    end
    du1 = clamp(uv_mem[b][0] - uv_mem[a][0], S32_MIN, S32_MAX);
    du2 = clamp(uv_mem[c][0] - uv_mem[a][0], S32_MIN, S32_MAX);
    dv1 = clamp(uv_mem[b][1] - uv_mem[a][1], S32_MIN, S32_MAX);
    dv2 = clamp(uv_mem[c][1] - uv_mem[a][1], S32_MIN, S32_MAX);
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) return;
    for (int k = 0; k < 3; k++) t[k] = div_q16(e1[k] * dv2 - e2[k] * dv1, det);
    for (int j = 0; j < 3; j++)
      for (int k = 0; k < 3; k++)
        sum_mem[corner[j]][k] = clamp(sum_mem[corner[j]][k] + t[k], S48_MIN, S48_MAX);
  endfunction

  // gram-schmidt against the normal, then normalize
  function automatic tangent_t finish_tangent(int v);
    wide_t t[3], u[3], res[3], dotraw, d, m, q;
    longint unsigned s2, len;
    int s;
    tangent_t r;
    r = '{32'sd0, 32'sd0, 32'sd0, 1'b1};
    dotraw = 0;
    m = 0;
    s2 = 0;
    for (int k = 0; k < 3; k++) begin
      t[k] = sum_mem[v][k];
      if (mag(t[k]) > m) m = mag(t[k]);
    end
    s = 0;
    while ((m >>> s) >= TWO30) s++;
    for (int k = 0; k < 3; k++) begin
      t[k] = shr_tz(t[k], s);
      dotraw += nrm_mem[v][k] * t[k];
    end
    d = clamp(shr_tz(dotraw, 16), S32_MIN, S32_MAX);
    m = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = t[k] - shr_tz(nrm_mem[v][k] * d, 16);
      if (mag(u[k]) > m) m = mag(u[k]);
    end
    if (m == 0) return r;
    s = 0;
    while ((m >>> s) >= TWO30) s++;
    for (int k = 0; k < 3; k++) u[k] = shr_tz(u[k], s);
    s = 0;
    if (m < TWO29) while ((m <<< s) < TWO29) s++;
    for (int k = 0; k < 3; k++) begin
      u[k] = u[k] <<< s;
      s2 += 64'(mag(u[k]) * mag(u[k]));
    end
    len = int_sqrt(s2);
    for (int k = 0; k < 3; k++) begin
      q = (mag(u[k]) <<< 16) / wide_t'(len);
      res[k] = u[k] < 0 ? -q : q;
    end
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
    r.zl = 1'b0;
    return r;
  endfunction

  // apply one accepted transaction to the predictor
  function automatic void predict(vtx_cmd_t cmd);
    tangent_t want;
    case (cmd.op)
      OP_LOAD: begin
        pos_mem[cmd.idx] = '{$signed(cmd.px), $signed(cmd.py), $signed(cmd.pz)};
        uv_mem[cmd.idx] = '{$signed(cmd.tu), $signed(cmd.tv)};
        nrm_mem[cmd.idx] = '{$signed(cmd.nx), $signed(cmd.ny), $signed(cmd.nz)};
        sum_mem[cmd.idx] = '{0, 0, 0};
        if (!loaded[cmd.idx]) loaded_list.push_back(cmd.idx);
        loaded[cmd.idx] = 1'b1;
      end
      OP_TRI: accumulate_triangle(cmd.idx, cmd.c2, cmd.c3);
      OP_READ: begin
        want = finish_tangent(cmd.idx);
        if (cmd.typed_zero) want = '{32'sd0, 32'sd0, 32'sd0, 1'b1};
        pending_tangents.push_back(want);
      end
      default: ;
    endcase
  endfunction

  function automatic vtx_cmd_t make_cmd(logic [1:0] op, int a, int b, int c,
      logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic [31:0] tu,
      logic [31:0] tv, logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, bit typed);
    vtx_cmd_t cmd;
    cmd = '{op, a[9:0], b[9:0], c[9:0], px, py, pz, tu, tv, nx, ny, nz, typed};
    return cmd;
  endfunction

  // mix of full-range, extreme and small Q16.16 values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return MAX_W;
      3: return MIN_W;
      default: return $urandom_range(0, 32'h60000) - 32'h30000;
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // drive one transaction and hold it until accepted
  task automatic issue(vtx_cmd_t cmd, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= cmd.op;
    in_vertex_index <= cmd.idx;
    in_second_corner <= cmd.c2;
    in_third_corner <= cmd.c3;
    in_position_x <= cmd.px;
    in_position_y <= cmd.py;
    in_position_z <= cmd.pz;
    in_tex_u <= cmd.tu;
    in_tex_v <= cmd.tv;
    in_normal_x <= cmd.nx;
    in_normal_y <= cmd.ny;
    in_normal_z <= cmd.nz;
    do @(posedge clk); while (busy);
    predict(cmd);
  endtask

  task automatic wait_results_done();
    while (pending_tangents.size() != 0) @(posedge clk);
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t mismatch on %s: expected %h actual %h", $time, field, want, got);
    failed = 1;
  endtask

  // result checker
  always @(posedge clk) begin
    tangent_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_tangents.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h %h %h %b", $time,
                 out_tangent_x, out_tangent_y, out_tangent_z, out_zero_length);
        failed = 1;
      end else begin
        want = pending_tangents.pop_front();
        if (out_tangent_x !== want.x) report("tangent_x", want.x, out_tangent_x);
        if (out_tangent_y !== want.y) report("tangent_y", want.y, out_tangent_y);
        if (out_tangent_z !== want.z) report("tangent_z", want.z, out_tangent_z);
        if (out_zero_length !== want.zl) report("zero_length", want.zl, out_zero_length);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    vtx_cmd_t cmd;
    int sel;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_LOAD;
    in_vertex_index <= '0;
    in_second_corner <= '0;
    in_third_corner <= '0;
    in_position_x <= '0;
    in_position_y <= '0;
    in_position_z <= '0;
    in_tex_u <= '0;
    in_tex_v <= '0;
    in_normal_x <= '0;
    in_normal_y <= '0;
    in_normal_z <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: unit triangle, zero determinant, extremes, normal-parallel tangent
    plan.push_back(make_cmd(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ONE_Q16, 0));
    plan.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan.push_back(make_cmd(OP_LOAD, 1, 0, 0, ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16, 0));
    plan.push_back(make_cmd(OP_LOAD, 2, 0, 0, 0, ONE_Q16, 0, 0, ONE_Q16, 0, 0, ONE_Q16, 0));
    plan.push_back(make_cmd(OP_TRI, 0, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_LOAD, 3, 0, 0, MAX_W, MIN_W, MAX_W, 0, 0, 0, ONE_Q16, 0, 0));
    plan.push_back(make_cmd(OP_LOAD, 4, 0, 0, MIN_W, MAX_W, 5, 0, 0, ONE_Q16, 0, 0, 0));
    plan.push_back(make_cmd(OP_TRI, 0, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan.push_back(make_cmd(OP_LOAD, 1023, 0, 0, MAX_W, MAX_W, MAX_W, MIN_W, MIN_W,
                            MIN_W, MIN_W, MIN_W, 0));
    plan.push_back(make_cmd(OP_LOAD, 5, 0, 0, MIN_W, MIN_W, MIN_W, MAX_W, 1, MAX_W,
                            MAX_W, MAX_W, 0));
    plan.push_back(make_cmd(OP_TRI, 1023, 5, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_TRI, 5, 5, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_UNUSED, 1023, 1023, 1023, MAX_W, MAX_W, MAX_W, MAX_W,
                            MAX_W, MAX_W, MAX_W, MAX_W, 0));
    plan.push_back(make_cmd(OP_TRI, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_LOAD, 7, 0, 0, 0, 0, 0, 0, 0, ONE_Q16, 0, 0, 0));
    plan.push_back(make_cmd(OP_LOAD, 8, 0, 0, ONE_Q16, 0, 0, ONE_Q16, 0, ONE_Q16, 0, 0, 0));
    plan.push_back(make_cmd(OP_LOAD, 9, 0, 0, 0, ONE_Q16, 0, 0, ONE_Q16, ONE_Q16, 0, 0, 0));
    plan.push_back(make_cmd(OP_TRI, 7, 8, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(make_cmd(OP_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    foreach (plan[i]) issue(plan[i], 0);

    // random part in three idle phases, mostly well-formed meshes
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 267; n++) begin
        sel = $urandom_range(0, 99);
        cmd = make_cmd($urandom, $urandom, $urandom, $urandom, rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), 0);
        if (sel < 28) begin
          cmd.op = OP_LOAD;
          cmd.idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 47);
        end else if (sel < 65) begin
          cmd.op = OP_TRI;
          cmd.idx = pick_loaded();
          cmd.c2 = pick_loaded();
          cmd.c3 = pick_loaded();
        end else if (sel < 95) begin
          cmd.op = OP_READ;
          cmd.idx = pick_loaded();
        end else begin
          cmd.op = OP_UNUSED;
        end
        issue(cmd, phase == 0 ? 35 : (phase == 1 ? 51 : 0));
      end
      // hold off until every pending result has come back
      if (phase == 0) begin
        start <= 1'b0;
        wait_results_done();
      end
    end

    start <= 1'b0;
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && pending_tangents.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
